@@ hw/rtl/sig_pkg.sv @@
`default_nettype none

package sig_pkg;

   // frame geometry
   localparam int LINES_PER_FRAME = 262;
   localparam int DOTS_PER_LINE   = 455;
   localparam int VERT_OFFSET     = 22;
   localparam int DOTS_PER_TICK   = 4;

   localparam int LINE_W  = 9;
   localparam int DOT_W   = 9;
   localparam int COUNT_W = 18;
   localparam int REG_W   = 8;

   // chip line = line counter + this bias, wrapped at the frame length
   localparam int CHIP_BIAS = LINES_PER_FRAME - (VERT_OFFSET % LINES_PER_FRAME);

   // mode register bits
   localparam int MODE_ENABLE_BIT    = 3;
   localparam int MODE_ONE_INSTR_BIT = 2;

   // item opcodes
   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_LINE_START = 2'd1,
      OP_CLEAR      = 2'd2
   } opcode_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_MATCH_LINE  = 2'd0,
      CSR_MODE_BITS   = 2'd1,
      CSR_VECTOR_BYTE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       acknowledge;
      logic       instruction_done;
   } item_type;

   typedef struct packed {
      logic [REG_W-1:0] match_line;
      logic [REG_W-1:0] mode_bits;
      logic [REG_W-1:0] vector_byte;
   } cfg_type;

   typedef struct packed {
      logic             int_level;
      logic [REG_W-1:0] ack_data;
      logic             line_complete;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/sig_core.sv @@
`default_nettype none

module sig_core
   import sig_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output      result_type result
);

   logic               asserted_ff, asserted_in;
   logic               one_instr_ff, one_instr_in;
   logic               armed_ff, armed_in;
   logic [COUNT_W-1:0] dots_left_ff, dots_left_in;
   logic [REG_W-1:0]   vector_ff, vector_in;
   logic [DOT_W-1:0]   dot_ff, dot_in;
   logic [LINE_W-1:0]  line_ff, line_in;

   logic [LINE_W-1:0]  lc_mod;
   logic [LINE_W:0]    chip_sum;
   logic [LINE_W:0]    chip_line;
   logic               line_hit;
   logic [LINE_W-1:0]  lines_left;
   logic [COUNT_W-1:0] total_dots;
   logic [COUNT_W-1:0] dot_wide;
   logic [DOT_W:0]     pos;
   logic [LINE_W:0]    line_next;
   logic [REG_W-1:0]   ack_data;
   logic               complete;

   // chip line number, match for line start, and dots left to the frame end
   always_comb begin
      lc_mod = (line_ff >= LINE_W'(LINES_PER_FRAME)) ?
               line_ff - LINE_W'(LINES_PER_FRAME) : line_ff;
      chip_sum  = {1'b0, lc_mod} + (LINE_W+1)'(CHIP_BIAS);
      chip_line = (chip_sum >= (LINE_W+1)'(LINES_PER_FRAME)) ?
                  chip_sum - (LINE_W+1)'(LINES_PER_FRAME) : chip_sum;
      line_hit  = (chip_line == {2'b00, cfg.match_line}) && cfg.mode_bits[MODE_ENABLE_BIT];
      lines_left = LINE_W'(LINES_PER_FRAME) - line_ff;
      total_dots = (line_ff < LINE_W'(LINES_PER_FRAME)) ?
                   COUNT_W'(lines_left) * COUNT_W'(DOTS_PER_LINE) : '0;
      dot_wide   = COUNT_W'(dot_ff);
   end

   // next state and result for one word
   always_comb begin
      asserted_in  = asserted_ff;
      one_instr_in = one_instr_ff;
      armed_in     = armed_ff;
      dots_left_in = dots_left_ff;
      vector_in    = vector_ff;
      dot_in       = dot_ff;
      line_in      = line_ff;
      ack_data     = '0;
      complete     = 1'b0;
      pos          = '0;
      line_next    = '0;
      unique case (item.opcode)
         OP_TICK: begin
            // acknowledge drives the vector and releases
            if (item.acknowledge) begin
               ack_data     = vector_ff;
               asserted_in  = 1'b0;
               one_instr_in = 1'b0;
               armed_in     = 1'b0;
               dots_left_in = '0;
            end
            // countdown to the next frame start
            if (armed_in) begin
               dots_left_in = (dots_left_in > COUNT_W'(DOTS_PER_TICK)) ?
                              dots_left_in - COUNT_W'(DOTS_PER_TICK) : '0;
               if (dots_left_in == '0) begin
                  asserted_in = 1'b0;
                  armed_in    = 1'b0;
               end
            end
            // release at instruction end
            if (item.instruction_done && one_instr_in) begin
               asserted_in  = 1'b0;
               one_instr_in = 1'b0;
            end
            // dot advance and line wrap
            pos = {1'b0, dot_ff} + (DOT_W+1)'(DOTS_PER_TICK);
            if (pos >= (DOT_W+1)'(DOTS_PER_LINE)) begin
               pos       = pos - (DOT_W+1)'(DOTS_PER_LINE);
               complete  = 1'b1;
               line_next = {1'b0, line_ff} + (LINE_W+1)'(1);
               if (line_next >= (LINE_W+1)'(LINES_PER_FRAME)) begin
                  line_next = '0;
               end
               line_in = line_next[LINE_W-1:0];
            end
            dot_in = pos[DOT_W-1:0];
         end
         OP_LINE_START: begin
            if (line_hit) begin
               asserted_in = 1'b1;
               vector_in   = cfg.vector_byte;
               if (!cfg.mode_bits[MODE_ONE_INSTR_BIT]) begin
                  one_instr_in = 1'b0;
                  armed_in     = 1'b1;
                  dots_left_in = (total_dots > dot_wide) ? total_dots - dot_wide : '0;
               end else begin
                  one_instr_in = 1'b1;
                  armed_in     = 1'b0;
                  dots_left_in = '0;
               end
            end
         end
         OP_CLEAR: begin
            asserted_in  = 1'b0;
            one_instr_in = 1'b0;
            armed_in     = 1'b0;
            dots_left_in = '0;
         end
         default: begin
         end
      endcase
      result.int_level     = asserted_in;
      result.ack_data      = ack_data;
      result.line_complete = complete;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         asserted_ff  <= 1'b0;
         one_instr_ff <= 1'b0;
         armed_ff     <= 1'b0;
         dots_left_ff <= '0;
         vector_ff    <= '0;
         dot_ff       <= '0;
         line_ff      <= '0;
      end else if (step) begin
         asserted_ff  <= asserted_in;
         one_instr_ff <= one_instr_in;
         armed_ff     <= armed_in;
         dots_left_ff <= dots_left_in;
         vector_ff    <= vector_in;
         dot_ff       <= dot_in;
         line_ff      <= line_in;
      end
   end

`ifndef SYNTHESIS
   a_armed_needs_line: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> asserted_ff)
      else $error("countdown armed while the line is released");

   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(armed_ff && one_instr_ff))
      else $error("hold and one-instruction modes both active");

   a_count_only_armed: assert property (@(posedge clock) disable iff (reset)
      (dots_left_ff != '0) |-> armed_ff)
      else $error("dots left while no countdown is armed");

   a_counters_in_range: assert property (@(posedge clock) disable iff (reset)
      (dot_ff < DOT_W'(DOTS_PER_LINE)) && (line_ff < LINE_W'(LINES_PER_FRAME)))
      else $error("dot or line counter out of range");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(dot_ff) && $stable(line_ff) && $stable(asserted_ff))
      else $error("state moved without a word");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/scanline_interrupt_generator_top.sv @@
// a request word is held in the input register, and its result is captured in
// the result register once the result side can take it
// throughput: one word per cycle back to back; a stalled result holds the core,
// and the request side takes one more word into the input register, then stalls
// reset: synchronous, active high; clears the configuration registers, the counters,
// the interrupt line and the latched vector, and empties both stages

`default_nettype none

module scanline_interrupt_generator_top
   import sig_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] acknowledge, [1] instruction_done, rest zero
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [0] int_level, [8:1] ack_data, rest zero
   output      logic        rsp_tlast,   // line_complete
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type core_result;
   logic       req_fire;
   logic       step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MATCH_LINE:  cfg_ff.match_line  <= csr_wdata;
            CSR_MODE_BITS:   cfg_ff.mode_bits   <= csr_wdata;
            CSR_VECTOR_BYTE: cfg_ff.vector_byte <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // stage handshake
   always_comb begin
      step         = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || step;
      req_fire     = req_tvalid && req_tready;
      in_valid_in  = req_fire || (in_valid_ff && !step);
      out_valid_in = step || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.opcode           <= req_tuser;
         in_item_ff.acknowledge      <= req_tdata[0];
         in_item_ff.instruction_done <= req_tdata[1];
      end
   end

   sig_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // result word register
   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.ack_data, out_ff.int_level};
   assign rsp_tlast  = out_ff.line_complete;

endmodule

`default_nettype wire
